>>> rtl/gain_scheduled_velocity_fusion_core_assert.svh
// Assertion macros for the velocity fusion core, empty in synthesis.
`ifndef GAIN_SCHEDULED_VELOCITY_FUSION_CORE_ASSERT_SVH
`define GAIN_SCHEDULED_VELOCITY_FUSION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GSVF_ASSERT_CLK(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);
`define GSVF_ASSERT(label, prop, msg) `GSVF_ASSERT_CLK(label, clk, rst_n, prop, msg)
`else
`define GSVF_ASSERT_CLK(label, clock, reset_n, prop, msg)
`define GSVF_ASSERT(label, prop, msg)
`endif
`endif

>>> rtl/gsvf_pkg.sv
// Types, constants and saturation helpers of the velocity fusion core.
`default_nettype none
package gsvf_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BIG    = 2'd1,
        MODE_STATIC = 2'd2
    } gain_mode_t;

    typedef enum logic [2:0] {
        REG_NORMAL_VEL_GAIN = 3'd0,
        REG_NORMAL_ACC_GAIN = 3'd1,
        REG_BIG_VEL_GAIN    = 3'd2,
        REG_BIG_ACC_GAIN    = 3'd3,
        REG_STATIC_VEL_GAIN = 3'd4,
        REG_STATIC_ACC_GAIN = 3'd5,
        REG_BIG_LIMIT_X     = 3'd6,
        REG_BIG_LIMIT_Y     = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_DT,
        ST_ADD_VP,
        ST_SUB_IN,
        ST_MUL_KV,
        ST_ADD_VN,
        ST_MUL_KA,
        ST_ADD_AN
    } state_t;

    typedef struct packed {
        logic signed [31:0] accel_sample;
        logic signed [31:0] measured_velocity;
        logic               axis_select;
        logic               support_change;
    } in_t;

    typedef struct packed {
        logic signed [31:0] velocity_estimate;
        logic signed [31:0] accel_state;
        gain_mode_t         gain_mode;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] value;
    } sat_t;

    localparam logic [3:0]         QUIET_TICK_LIMIT = 4'd10;
    localparam logic [3:0]         QUIET_MAX        = 4'd15;
    localparam logic [3:0]         SUPPORT_HOLD_X   = 4'd2;
    localparam logic [3:0]         SUPPORT_HOLD_Y   = 4'd12;
    localparam logic signed [31:0] DT_Q             = 32'sd675;
    localparam logic signed [31:0] ACC_SCALE        = 32'sd100;
    localparam logic [31:0]        SMALL_ACC_Q      = 32'd1310720;
    localparam logic signed [63:0] ROUND_HALF       = 64'sd32768;
    localparam logic signed [31:0] S32_MAX          = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN          = 32'sh8000_0000;
    localparam logic signed [31:0] STATIC_VEL_RESET = 32'sd65536;
    localparam logic [30:0]        LIMIT_X_RESET    = 31'd13107200;
    localparam logic [30:0]        LIMIT_Y_RESET    = 31'd6553600;

    // Clip a 64-bit value to the signed 32-bit range.
    function automatic sat_t sat64(input logic signed [63:0] x);
        sat_t r;
        r.clip  = !((&x[63:31]) || !(|x[63:31]));
        r.value = r.clip ? (x[63] ? S32_MIN : S32_MAX) : x[31:0];
        return r;
    endfunction

    // Clip a 33-bit sum or difference to the signed 32-bit range.
    function automatic sat_t sat33(input logic [32:0] x);
        sat_t r;
        r.clip  = x[32] ^ x[31];
        r.value = r.clip ? (x[32] ? S32_MIN : S32_MAX) : x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/gain_scheduled_velocity_fusion_core.sv
// Gain-scheduled two-state velocity fusion filter built round one shared multiplier and adder.
//
// Usage:
//  - Input channel (in_valid / in_ready / in_data): one item per axis tick carries an
//    acceleration sample, a measured velocity, the axis (1 = x, 0 = y) and a support-change flag.
//  - Output channel (out_valid / out_ready / out_data): one item per input item with the new
//    velocity estimate, the corrected acceleration state, the gain mode used and a clip flag.
//  - Configuration (cfg_we / cfg_index / cfg_data): six Q16.16 gains and two big-acceleration
//    limits. Write them only while the block is idle; the block itself does not enforce this.
//  - Sequence: after acceptance, a sequencer chooses the gain and scales the sample, then steps
//    the item through three multiplies and four saturating adds on a single 32x32 multiplier and
//    a single 33-bit adder, one operation per cycle unless the last step is held for the output.
//  - in_ready is high only while the sequencer is idle; a new item waits until the last one is done.
//  - The output register holds a finished item while the next item is being worked on; if it is
//    still full when the following result is ready, the sequencer holds on its last step.
//  - Reset clears the velocity estimates and both counters of each axis and loads the default
//    gains and limits; no memory is cleared, so the block is ready the cycle after reset.
`default_nettype none
`include "gain_scheduled_velocity_fusion_core_assert.svh"
module gain_scheduled_velocity_fusion_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gsvf_pkg::in_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gsvf_pkg::out_t     out_data,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    gsvf_pkg::state_t     state_reg, state_next;

    logic signed [31:0]   normal_vel_gain_reg, normal_acc_gain_reg;
    logic signed [31:0]   big_vel_gain_reg, big_acc_gain_reg;
    logic signed [31:0]   static_vel_gain_reg, static_acc_gain_reg;
    logic [30:0]          big_limit_x_reg, big_limit_y_reg;

    logic signed [31:0]   vel_est_reg [2];
    logic [3:0]           quiet_reg [2];
    logic [3:0]           support_reg [2];

    gsvf_pkg::in_t        item_reg;
    gsvf_pkg::gain_mode_t mode_reg;
    logic signed [31:0]   a_pred_reg, v_pred_reg, innov_reg, prod_reg, v_new_reg;
    logic                 clip_reg;
    logic                 out_valid_reg;
    gsvf_pkg::out_t       out_data_reg;

    // Sequencer controls for the shared units
    logic signed [31:0]   mul_a, mul_b;
    logic                 mul_q16;
    logic signed [31:0]   add_a, add_b;
    logic                 add_sub;
    logic                 advance;

    logic                 ax;
    logic signed [31:0]   kv, ka;

    // Gain choice
    logic [3:0]           hold;
    logic [3:0]           sc, q;
    logic [3:0]           sc_next, q_next;
    logic [31:0]          mag;
    gsvf_pkg::gain_mode_t mode_next;

    logic signed [63:0]   product, rounded;
    gsvf_pkg::sat_t       mul_res, add_res;
    logic [32:0]          add_sum;

    assign ax = ~item_reg.axis_select;

    always_comb
    begin
        unique case (mode_reg)
            gsvf_pkg::MODE_BIG:
            begin
                kv = big_vel_gain_reg;
                ka = big_acc_gain_reg;
            end
            gsvf_pkg::MODE_STATIC:
            begin
                kv = static_vel_gain_reg;
                ka = static_acc_gain_reg;
            end
            default:
            begin
                kv = normal_vel_gain_reg;
                ka = normal_acc_gain_reg;
            end
        endcase
    end

    always_comb
    begin
        hold      = ax ? gsvf_pkg::SUPPORT_HOLD_Y : gsvf_pkg::SUPPORT_HOLD_X;
        sc        = support_reg[ax];
        q         = quiet_reg[ax];
        mag       = item_reg.accel_sample[31] ? (~item_reg.accel_sample + 32'd1)
                                              : item_reg.accel_sample;
        sc_next   = sc;
        q_next    = q;
        mode_next = gsvf_pkg::MODE_NORMAL;
        if ((item_reg.support_change || sc != 4'd0) && sc >= hold)
        begin
            sc_next   = 4'd0;
            mode_next = gsvf_pkg::MODE_STATIC;
        end
        else
        begin
            if (item_reg.support_change || sc != 4'd0)
            begin
                sc_next = sc + 4'd1;
            end
            priority if (mag < gsvf_pkg::SMALL_ACC_Q)
            begin
                q_next    = (q < gsvf_pkg::QUIET_MAX) ? q + 4'd1 : q;
                mode_next = (q_next > gsvf_pkg::QUIET_TICK_LIMIT) ? gsvf_pkg::MODE_STATIC
                                                                 : gsvf_pkg::MODE_NORMAL;
            end
            else if (mag > {1'b0, (ax ? big_limit_y_reg : big_limit_x_reg)})
            begin
                mode_next = gsvf_pkg::MODE_BIG;
            end
            else
            begin
                q_next    = 4'd0;
                mode_next = gsvf_pkg::MODE_NORMAL;
            end
        end
    end

    // Shared multiplier: raw product or Q16.16 rounded half up, both clipped
    assign product = mul_a * mul_b;
    assign rounded = (product + gsvf_pkg::ROUND_HALF) >>> 16;
    assign mul_res = gsvf_pkg::sat64(mul_q16 ? rounded : product);

    // Shared adder
    assign add_sum = add_sub ? ({add_a[31], add_a} - {add_b[31], add_b})
                             : ({add_a[31], add_a} + {add_b[31], add_b});
    assign add_res = gsvf_pkg::sat33(add_sum);

    assign advance = (state_reg != gsvf_pkg::ST_ADD_AN) || !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsvf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = a_pred_reg;
        mul_b      = gsvf_pkg::DT_Q;
        mul_q16    = 1'b1;
        add_a      = v_pred_reg;
        add_b      = prod_reg;
        add_sub    = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            gsvf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = gsvf_pkg::ST_DECIDE;
                end
            end
            gsvf_pkg::ST_DECIDE:
            begin
                mul_a      = item_reg.accel_sample;
                mul_b      = gsvf_pkg::ACC_SCALE;
                mul_q16    = 1'b0;
                state_next = gsvf_pkg::ST_MUL_DT;
            end
            gsvf_pkg::ST_MUL_DT:
            begin
                state_next = gsvf_pkg::ST_ADD_VP;
            end
            gsvf_pkg::ST_ADD_VP:
            begin
                add_a      = vel_est_reg[ax];
                state_next = gsvf_pkg::ST_SUB_IN;
            end
            gsvf_pkg::ST_SUB_IN:
            begin
                add_a      = item_reg.measured_velocity;
                add_b      = v_pred_reg;
                add_sub    = 1'b1;
                state_next = gsvf_pkg::ST_MUL_KV;
            end
            gsvf_pkg::ST_MUL_KV:
            begin
                mul_a      = kv;
                mul_b      = innov_reg;
                state_next = gsvf_pkg::ST_ADD_VN;
            end
            gsvf_pkg::ST_ADD_VN:
            begin
                state_next = gsvf_pkg::ST_MUL_KA;
            end
            gsvf_pkg::ST_MUL_KA:
            begin
                mul_a      = ka;
                mul_b      = innov_reg;
                state_next = gsvf_pkg::ST_ADD_AN;
            end
            gsvf_pkg::ST_ADD_AN:
            begin
                add_a = a_pred_reg;
                if (advance)
                begin
                    state_next = gsvf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsvf_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_vel_gain_reg <= '0;
            normal_acc_gain_reg <= '0;
            big_vel_gain_reg    <= '0;
            big_acc_gain_reg    <= '0;
            static_vel_gain_reg <= gsvf_pkg::STATIC_VEL_RESET;
            static_acc_gain_reg <= '0;
            big_limit_x_reg     <= gsvf_pkg::LIMIT_X_RESET;
            big_limit_y_reg     <= gsvf_pkg::LIMIT_Y_RESET;
        end
        else if (cfg_we)
        begin
            unique case (gsvf_pkg::reg_index_t'(cfg_index))
                gsvf_pkg::REG_NORMAL_VEL_GAIN: normal_vel_gain_reg <= cfg_data;
                gsvf_pkg::REG_NORMAL_ACC_GAIN: normal_acc_gain_reg <= cfg_data;
                gsvf_pkg::REG_BIG_VEL_GAIN:    big_vel_gain_reg    <= cfg_data;
                gsvf_pkg::REG_BIG_ACC_GAIN:    big_acc_gain_reg    <= cfg_data;
                gsvf_pkg::REG_STATIC_VEL_GAIN: static_vel_gain_reg <= cfg_data;
                gsvf_pkg::REG_STATIC_ACC_GAIN: static_acc_gain_reg <= cfg_data;
                gsvf_pkg::REG_BIG_LIMIT_X:     big_limit_x_reg     <= cfg_data[30:0];
                gsvf_pkg::REG_BIG_LIMIT_Y:     big_limit_y_reg     <= cfg_data[30:0];
                default:                       big_limit_y_reg     <= big_limit_y_reg;
            endcase
        end
    end

    // Per-axis filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                vel_est_reg[i] <= '0;
                quiet_reg[i]   <= '0;
                support_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == gsvf_pkg::ST_DECIDE)
            begin
                quiet_reg[ax]   <= q_next;
                support_reg[ax] <= sc_next;
            end
            if (state_reg == gsvf_pkg::ST_ADD_AN && advance)
            begin
                vel_est_reg[ax] <= v_new_reg;
            end
        end
    end

    // Working registers of one item
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gsvf_pkg::ST_IDLE:
            begin
                item_reg <= in_data;
                clip_reg <= 1'b0;
            end
            gsvf_pkg::ST_DECIDE:
            begin
                mode_reg   <= mode_next;
                a_pred_reg <= mul_res.value;
                clip_reg   <= clip_reg | mul_res.clip;
            end
            gsvf_pkg::ST_MUL_DT, gsvf_pkg::ST_MUL_KV, gsvf_pkg::ST_MUL_KA:
            begin
                prod_reg <= mul_res.value;
                clip_reg <= clip_reg | mul_res.clip;
            end
            gsvf_pkg::ST_ADD_VP:
            begin
                v_pred_reg <= add_res.value;
                clip_reg   <= clip_reg | add_res.clip;
            end
            gsvf_pkg::ST_SUB_IN:
            begin
                innov_reg <= add_res.value;
                clip_reg  <= clip_reg | add_res.clip;
            end
            gsvf_pkg::ST_ADD_VN:
            begin
                v_new_reg <= add_res.value;
                clip_reg  <= clip_reg | add_res.clip;
            end
            default:
            begin
                clip_reg <= clip_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == gsvf_pkg::ST_ADD_AN && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gsvf_pkg::ST_ADD_AN && advance)
        begin
            out_data_reg.velocity_estimate <= v_new_reg;
            out_data_reg.accel_state       <= add_res.value;
            out_data_reg.gain_mode         <= mode_reg;
            out_data_reg.saturated         <= clip_reg | add_res.clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `GSVF_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
    `GSVF_ASSERT(a_out_from_last_step, $rose(out_valid) |-> $past(state_reg == gsvf_pkg::ST_ADD_AN), "output without last step")
    `GSVF_ASSERT(a_support_x_bound, support_reg[0] <= gsvf_pkg::SUPPORT_HOLD_X, "x support count past hold")
    `GSVF_ASSERT(a_support_y_bound, support_reg[1] <= gsvf_pkg::SUPPORT_HOLD_Y, "y support count past hold")
    `GSVF_ASSERT(a_no_overwrite, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "pending result overwritten")

endmodule
`default_nettype wire
